### src/ecal_pkg.sv
// Package for the epoch seconds to calendar converter.
// Holds time constants, the month length table in seconds and the compare/subtract result type.
// No dependencies.
package ecal_pkg;

  localparam logic [31:0] SECS_PER_MIN  = 32'd60;
  localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [31:0] SECS_PER_YEAR = 32'd365 * SECS_PER_DAY;
  localparam logic [31:0] SECS_PER_LEAP = 32'd366 * SECS_PER_DAY;
  localparam logic [10:0] FIRST_YEAR    = 11'd1900;

  // Result of the shared compare/subtract unit.
  typedef struct packed {
    logic        ge;
    logic [31:0] diff;
  } ecal_cmp_t;

  // Length in seconds of month mon (1 is January).
  function automatic logic [31:0] month_secs(input logic [3:0] mon, input logic leap);
    logic [31:0] len;
    begin
      case (mon)
        4'd2:                      len = 32'd28 * SECS_PER_DAY;
        4'd4, 4'd6, 4'd9, 4'd11:   len = 32'd30 * SECS_PER_DAY;
        default:                   len = 32'd31 * SECS_PER_DAY;
      endcase
      if (mon == 4'd2 && leap) begin
        len = len + SECS_PER_DAY;
      end
      return len;
    end
  endfunction

endpackage

### src/ecal_sub.sv
// Shared compare/subtract unit of the calendar converter.
// Depends on ecal_pkg for the result type.
// Reports whether the remainder covers the subtrahend and the difference.
module ecal_sub
  import ecal_pkg::*;
(
  input  logic [31:0] rem,
  input  logic [31:0] sub,
  output ecal_cmp_t   res
);

  logic [32:0] wide;

  assign wide     = {1'b0, rem} - {1'b0, sub};
  assign res.ge   = ~wide[32];
  assign res.diff = wide[31:0];

endmodule

### src/epoch_seconds_to_calendar_unit.sv
// Epoch seconds to Gregorian calendar date and time converter, top level.
// Uses ecal_pkg and the shared compare/subtract unit ecal_sub.
//
// Usage: drive epoch_seconds (seconds since 1900-01-01 00:00:00) and raise
// start. The transfer happens at a rising edge where start is high and busy
// is low. busy then stays high while the block works. The result appears on
// year, month, day, hour, minute and second for exactly one cycle, marked by
// done; the receiver must take it in that cycle, since it cannot stall the
// block. busy is low in the done cycle, so a new start may be taken then.
//
// The work is done by one 32-bit compare/subtract unit stepped by a small
// sequencer: it removes whole years, then months, days, hours and minutes
// from the seconds count, one subtraction per cycle, and each phase ends
// on a compare that does not subtract. One item is in flight at a time.
//
// Synchronous active-high reset returns the sequencer to idle and clears
// busy and done; the result ports hold no meaning outside the done cycle.
module epoch_seconds_to_calendar_unit
  import ecal_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] epoch_seconds,
  output logic        busy,
  output logic        done,
  output logic [10:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MONTH,
    ST_DAY,
    ST_HOUR,
    ST_MIN
  } state_t;

  state_t      state;
  logic [31:0] rem;
  logic [1:0]  mod4;
  logic [6:0]  mod100;
  logic [8:0]  mod400;
  logic        leap;
  logic [31:0] sub;
  ecal_cmp_t   cmp;

  assign leap   = (mod4 == 2'd0) && ((mod100 != 7'd0) || (mod400 == 9'd0));
  assign second = rem[5:0];

  always_comb begin
    case (state)
      ST_YEAR:  sub = leap ? SECS_PER_LEAP : SECS_PER_YEAR;
      ST_MONTH: sub = month_secs(month, leap);
      ST_DAY:   sub = SECS_PER_DAY;
      ST_HOUR:  sub = SECS_PER_HOUR;
      ST_MIN:   sub = SECS_PER_MIN;
      default:  sub = SECS_PER_MIN;
    endcase
  end

  ecal_sub u_sub (
    .rem (rem),
    .sub (sub),
    .res (cmp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state  <= ST_YEAR;
            busy   <= 1'b1;
            rem    <= epoch_seconds;
            year   <= FIRST_YEAR;
            mod4   <= 2'd0;
            mod100 <= 7'd0;
            mod400 <= 9'd300;
            month  <= 4'd1;
            day    <= 5'd1;
            hour   <= 5'd0;
            minute <= 6'd0;
          end
        end
        ST_YEAR: begin
          if (cmp.ge) begin
            rem    <= cmp.diff;
            year   <= year + 11'd1;
            mod4   <= mod4 + 2'd1;
            mod100 <= (mod100 == 7'd99) ? 7'd0 : mod100 + 7'd1;
            mod400 <= (mod400 == 9'd399) ? 9'd0 : mod400 + 9'd1;
          end else begin
            state <= ST_MONTH;
          end
        end
        ST_MONTH: begin
          // December is never subtracted: what is left always fits in it.
          if (cmp.ge && month != 4'd12) begin
            rem   <= cmp.diff;
            month <= month + 4'd1;
          end else begin
            state <= ST_DAY;
          end
        end
        ST_DAY: begin
          if (cmp.ge) begin
            rem <= cmp.diff;
            day <= day + 5'd1;
          end else begin
            state <= ST_HOUR;
          end
        end
        ST_HOUR: begin
          if (cmp.ge) begin
            rem  <= cmp.diff;
            hour <= hour + 5'd1;
          end else begin
            state <= ST_MIN;
          end
        end
        ST_MIN: begin
          if (cmp.ge) begin
            rem    <= cmp.diff;
            minute <= minute + 6'd1;
          end else begin
            state <= ST_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("done without a preceding busy period");

  a_start_sets_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    done |-> month >= 4'd1 && month <= 4'd12 && day >= 5'd1 && day <= 5'd31 &&
             hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59)
    else $error("result field out of range");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

endmodule
